### hw/rtl/gwm_pkg.sv
// Shared constants, register codes and the cell link type of the wildcard glob matcher.
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

  // Parameter defaults.
  localparam int unsigned MAX_PATTERN_DEF = 16;
  localparam int unsigned CHAR_BITS_DEF   = 16;

  // Pattern register layout.
  localparam int unsigned WORD_COUNT     = 4;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned SLOT_BITS      = 16;
  localparam int unsigned SLOTS_PER_WORD = WORD_BITS / SLOT_BITS;
  localparam int unsigned HELD_CHARS     = WORD_COUNT * SLOTS_PER_WORD;
  localparam int unsigned LEN_BITS       = 5;

  // APB: 64-bit registers at byte address 8*index.
  localparam int unsigned APB_DATA_BITS  = 64;
  localparam int unsigned APB_ADDR_BITS  = 6;
  localparam int unsigned REG_IDX_LSB    = 3;
  localparam int unsigned REG_IDX_BITS   = APB_ADDR_BITS - REG_IDX_LSB;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_WORD_0 = 3'd0,
    REG_WORD_1 = 3'd1,
    REG_WORD_2 = 3'd2,
    REG_WORD_3 = 3'd3,
    REG_LENGTH = 3'd4
  } reg_idx_e;

  // Wildcard characters.
  localparam logic [7:0] STAR_CHAR     = 8'h2A;
  localparam logic [7:0] QUESTION_CHAR = 8'h3F;

  // Signals that one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic in_use;      // this and every position to the left are inside the pattern
    logic star_carry;  // closure of the current set through a star
    logic adv;         // a character match advances into the next position
    logic next_carry;  // closure of the updated set through a star
  } link_t;

endpackage

`default_nettype wire

### hw/rtl/gwm_ch_if.sv
// Input character channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface gwm_ch_if #(
  parameter int unsigned CharBits = gwm_pkg::CHAR_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [CharBits-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

`default_nettype wire

### hw/rtl/gwm_res_if.sv
// Result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface gwm_res_if ();
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink (input valid, input matched, output ready);
endinterface

`default_nettype wire

### hw/rtl/gwm_cfg_regs.sv
// APB register file holding the pattern characters and the pattern length.
`timescale 1ns / 1ps
`default_nettype none

module gwm_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [gwm_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  wire logic [gwm_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic      [gwm_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                     pready,
  output logic [gwm_pkg::WORD_COUNT-1:0][gwm_pkg::WORD_BITS-1:0] words_o,
  output logic      [gwm_pkg::LEN_BITS-1:0]        length_o
);

  logic [gwm_pkg::WORD_COUNT-1:0][gwm_pkg::WORD_BITS-1:0] words_q, words_d;
  logic [gwm_pkg::LEN_BITS-1:0]                           length_q, length_d;
  gwm_pkg::reg_idx_e                                      idx;
  logic                                                   wr_en;

  assign idx    = gwm_pkg::reg_idx_e'(paddr[gwm_pkg::APB_ADDR_BITS-1:gwm_pkg::REG_IDX_LSB]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    words_d  = words_q;
    length_d = length_q;
    if (wr_en) begin
      unique case (idx)
        gwm_pkg::REG_WORD_0: words_d[0] = pwdata;
        gwm_pkg::REG_WORD_1: words_d[1] = pwdata;
        gwm_pkg::REG_WORD_2: words_d[2] = pwdata;
        gwm_pkg::REG_WORD_3: words_d[3] = pwdata;
        gwm_pkg::REG_LENGTH: length_d = pwdata[gwm_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gwm_pkg::REG_WORD_0: prdata = words_q[0];
      gwm_pkg::REG_WORD_1: prdata = words_q[1];
      gwm_pkg::REG_WORD_2: prdata = words_q[2];
      gwm_pkg::REG_WORD_3: prdata = words_q[3];
      gwm_pkg::REG_LENGTH: prdata = gwm_pkg::APB_DATA_BITS'(length_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q  <= '0;
      length_q <= '0;
    end else begin
      words_q  <= words_d;
      length_q <= length_d;
    end
  end

  assign words_o  = words_q;
  assign length_o = length_q;

endmodule

`default_nettype wire

### hw/rtl/gwm_cell.sv
// One pattern position: holds its active bit and passes closure and match signals right.
`timescale 1ns / 1ps
`default_nettype none

module gwm_cell #(
  parameter int unsigned CharBits = gwm_pkg::CHAR_BITS_DEF,
  parameter bit          IsStart  = 1'b0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [CharBits-1:0] pchar_i,
  input  wire logic                clamp_ok_i,
  input  wire logic [CharBits-1:0] ch_i,
  input  wire gwm_pkg::link_t      left_i,
  input  wire logic                step_i,
  input  wire logic                restart_i,
  output gwm_pkg::link_t           right_o,
  output logic                     act_o,
  output logic                     at_end_o,
  output logic                     end_hit_o
);

  logic act_q, act_d;
  logic in_use, is_star, is_any, closed, keep, raw_next, next_closed;

  assign in_use  = left_i.in_use & clamp_ok_i & (pchar_i != '0);
  assign is_star = (pchar_i == CharBits'(gwm_pkg::STAR_CHAR));
  assign is_any  = (pchar_i == CharBits'(gwm_pkg::QUESTION_CHAR));

  // Active after closing over any run of stars to the left.
  assign closed = act_q | left_i.star_carry;
  // A star keeps its own position alive; the next position sees the star via closure.
  assign keep   = closed & in_use & is_star;

  assign raw_next    = keep | left_i.adv;
  assign next_closed = raw_next | left_i.next_carry;

  assign right_o.in_use     = in_use;
  assign right_o.star_carry = keep;
  assign right_o.adv        = closed & in_use & ~is_star & (is_any | (pchar_i == ch_i));
  assign right_o.next_carry = next_closed & in_use & is_star;

  // This cell is the position just past the last pattern character in use.
  assign at_end_o  = left_i.in_use & ~in_use;
  assign end_hit_o = closed & at_end_o;

  always_comb begin
    act_d = act_q;
    priority if (restart_i) begin
      act_d = IsStart;
    end else if (step_i) begin
      act_d = next_closed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= IsStart;
    end else begin
      act_q <= act_d;
    end
  end

  assign act_o = act_q;

endmodule

`default_nettype wire

### hw/rtl/wildcard_glob_matcher_top.sv
// Top level of the wildcard glob matcher: register file, row of position cells, result register.
`timescale 1ns / 1ps
`default_nettype none

// Streams characters against a '*' / '?' wildcard pattern of up to MaxPattern
// characters (at most sixteen held in the registers). One character is taken
// every cycle unless the input stalls; a zero character ends the string and its
// match result appears on the result channel in the next cycle, after which
// matching restarts for the next string. The whole update of the position set
// is combinational in a row of MaxPattern+1 cells, one per pattern position; the
// star closure ripples through the row like a carry chain, so the clock period
// is set by the row length. The input stalls only while a result waits
// unaccepted on the output. No clearing pass is needed after reset.
module wildcard_glob_matcher_top #(
  parameter int unsigned MaxPattern = gwm_pkg::MAX_PATTERN_DEF,
  parameter int unsigned CharBits   = gwm_pkg::CHAR_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [gwm_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [gwm_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [gwm_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                   pready,
  gwm_ch_if.sink                                 ch_i,
  gwm_res_if.source                              res_o
);

  localparam int unsigned NumCells = MaxPattern + 1;

  logic [gwm_pkg::WORD_COUNT-1:0][gwm_pkg::WORD_BITS-1:0] words;
  logic [gwm_pkg::LEN_BITS-1:0]                           length;

  gwm_pkg::link_t      link [NumCells+1];
  logic [CharBits-1:0] pchar [NumCells];
  logic [NumCells-1:0] clamp_ok, use_vec, act_vec, at_end_vec, end_hit_vec;

  logic accept, is_term, step, restart;
  logic out_valid_q, out_valid_d, matched_q, matched_d;

  gwm_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .words_o  (words),
    .length_o (length)
  );

  assign accept  = ch_i.valid & ch_i.ready;
  assign is_term = (ch_i.ch == '0);
  assign step    = accept & ~is_term;
  assign restart = accept & is_term;

  // Position zero always starts inside the pattern.
  assign link[0] = '{in_use: 1'b1, star_carry: 1'b0, adv: 1'b0, next_carry: 1'b0};

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    if ((i < gwm_pkg::HELD_CHARS) && (i < MaxPattern)) begin : g_held
      assign pchar[i] = words[i / gwm_pkg::SLOTS_PER_WORD]
                             [(i % gwm_pkg::SLOTS_PER_WORD) * gwm_pkg::SLOT_BITS +: CharBits];
      assign clamp_ok[i] = (32'(length) > 32'(i));
    end else begin : g_empty
      // Positions past the held characters, and the final position, read as zero.
      assign pchar[i]    = '0;
      assign clamp_ok[i] = 1'b0;
    end

    gwm_cell #(
      .CharBits (CharBits),
      .IsStart  (i == 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .pchar_i   (pchar[i]),
      .clamp_ok_i(clamp_ok[i]),
      .ch_i      (ch_i.ch),
      .left_i    (link[i]),
      .step_i    (step),
      .restart_i (restart),
      .right_o   (link[i+1]),
      .act_o     (act_vec[i]),
      .at_end_o  (at_end_vec[i]),
      .end_hit_o (end_hit_vec[i])
    );

    assign use_vec[i] = link[i+1].in_use;
  end

  // A pending result must be taken before the next character is.
  assign ch_i.ready = ~out_valid_q | res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    priority if (restart) begin
      out_valid_d = 1'b1;
      matched_d   = |end_hit_vec;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.matched = matched_q;

  // The positions in use form one run starting at position zero.
  a_use_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((use_vec & (use_vec + 1'b1)) == '0))
    else $error("pattern positions in use are not a prefix");

  // Exactly one position marks the end of the pattern.
  a_one_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(at_end_vec))
    else $error("end of pattern is not a single position");

  // A terminator returns the set to the start position.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> (act_vec == NumCells'(1)))
    else $error("position set not restarted after terminator");

  // No character is taken while a result is stalled on the output.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(out_valid_q && !res_o.ready))
    else $error("character taken while result stalled");

  // A non-terminator never creates a result.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !out_valid_q) |=> !out_valid_q)
    else $error("result created by a non-terminator");

endmodule

`default_nettype wire

### bench/tb_wildcard_glob_matcher_top.sv
// Self-checking bench for the wildcard glob matcher: directed and random strings and patterns.
`timescale 1ns / 1ps

module tb_wildcard_glob_matcher_top;

  localparam int unsigned CLK_HALF     = 2;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned QUIET_FROM   = 600;
  localparam int unsigned QUIET_TO     = 950;
  localparam logic [15:0] CHAR_MASK    = 16'((32'd1 << gwm_pkg::CHAR_BITS_DEF) - 32'd1);
  localparam logic [15:0] STAR16       = 16'(gwm_pkg::STAR_CHAR);
  localparam logic [15:0] QUEST16      = 16'(gwm_pkg::QUESTION_CHAR);
  localparam logic [15:0] END_CHAR     = 16'h0000;

  // Tracks the reachable pattern positions and queues the match flag of each string.
  class match_scoreboard;
    logic [gwm_pkg::WORD_BITS-1:0]     pat_word [gwm_pkg::WORD_COUNT];
    logic [gwm_pkg::LEN_BITS-1:0]      pat_len;
    logic [gwm_pkg::MAX_PATTERN_DEF:0] live;
    bit                                expected_match[$];
    int unsigned                       errors;
    int unsigned                       n_chars;
    int unsigned                       n_strings;
    int unsigned                       n_hits;

    function new();
      foreach (pat_word[k]) pat_word[k] = '0;
      pat_len   = '0;
      live      = '0;
      live[0]   = 1'b1;
      errors    = 0;
      n_chars   = 0;
      n_strings = 0;
      n_hits    = 0;
    endfunction

    function void write_reg(gwm_pkg::reg_idx_e idx, logic [gwm_pkg::WORD_BITS-1:0] v);
      if (idx == gwm_pkg::REG_LENGTH) begin
        pat_len = v[gwm_pkg::LEN_BITS-1:0];
      end else begin
        pat_word[int'(idx)] = v;
      end
    endfunction

    function logic [15:0] pat_char(int unsigned i);
      logic [gwm_pkg::WORD_BITS-1:0] w;
      if (i >= gwm_pkg::HELD_CHARS) return '0;
      w = pat_word[i / gwm_pkg::SLOTS_PER_WORD];
      return 16'(w >> ((i % gwm_pkg::SLOTS_PER_WORD) * gwm_pkg::SLOT_BITS)) & CHAR_MASK;
    endfunction

    // The pattern stops at its first zero character.
    function int unsigned eff_len();
      int unsigned n;
      n = pat_len;
      if (n > gwm_pkg::MAX_PATTERN_DEF) n = gwm_pkg::MAX_PATTERN_DEF;
      for (int unsigned i = 0; i < n; i++) begin
        if (pat_char(i) == '0) return i;
      end
      return n;
    endfunction

    // Ascending order lets a run of stars carry all the way through.
    function void close_stars(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
        if (live[i] && pat_char(i) == STAR16) live[i+1] = 1'b1;
      end
    endfunction

    function void note_char(logic [15:0] c);
      logic [15:0]                       cm;
      logic [15:0]                       p;
      int unsigned                       n;
      logic [gwm_pkg::MAX_PATTERN_DEF:0] moved;
      cm = c & CHAR_MASK;
      n  = eff_len();
      n_chars++;
      close_stars(n);
      if (cm == '0) begin
        expected_match.push_back(live[n]);
        live    = '0;
        live[0] = 1'b1;
        n_strings++;
        return;
      end
      moved = '0;
      for (int unsigned i = 0; i < n; i++) begin
        if (live[i]) begin
          p = pat_char(i);
          if (p == STAR16) begin
            moved[i] = 1'b1;
          end else if (p == QUEST16 || p == cm) begin
            moved[i+1] = 1'b1;
          end
        end
      end
      live = moved;
      close_stars(n);
    endfunction

    function void check_result(logic matched);
      bit want;
      if (expected_match.size() == 0) begin
        $error("unexpected result transfer: matched=%0b", matched);
        errors++;
        return;
      end
      want = expected_match.pop_front();
      if (matched !== want) begin
        $error("field matched: expected %0b, actual %0b", want, matched);
        errors++;
      end else if (want) begin
        n_hits++;
      end
    endfunction

    function int unsigned pending();
      return expected_match.size();
    endfunction
  endclass

  logic                              clk;
  logic                              rst_ni;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [gwm_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [gwm_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [gwm_pkg::APB_DATA_BITS-1:0] prdata;
  logic                              pready;
  bit                                quiet;
  logic [15:0]                       text[$];
  int unsigned                       phases;
  match_scoreboard                   sb = new();

  gwm_ch_if #(.CharBits(gwm_pkg::CHAR_BITS_DEF)) ch_if ();
  gwm_res_if res_if ();

  wildcard_glob_matcher_top #(
    .MaxPattern(gwm_pkg::MAX_PATTERN_DEF),
    .CharBits  (gwm_pkg::CHAR_BITS_DEF)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .ch_i   (ch_if),
    .res_o  (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side backpressure.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= quiet || ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && res_if.valid && res_if.ready) sb.check_result(res_if.matched);
  end

  // The bus stays selected afterwards; program_pattern returns it to idle.
  task automatic reg_write(input gwm_pkg::reg_idx_e idx,
                           input logic [gwm_pkg::APB_DATA_BITS-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {gwm_pkg::REG_IDX_LSB{1'b0}}};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, v);
  endtask

  task automatic program_pattern(input logic [255:0] pk, input logic [63:0] len_word);
    for (int k = 0; k < gwm_pkg::WORD_COUNT; k++) begin
      reg_write(gwm_pkg::reg_idx_e'(k), pk[64*k +: 64]);
    end
    reg_write(gwm_pkg::REG_LENGTH, len_word);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Lowers valid and waits until the last terminator's result has been seen.
  task automatic settle();
    ch_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_char(input logic [15:0] c);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      ch_if.valid <= 1'b0;
      @(posedge clk);
    end
    ch_if.valid <= 1'b1;
    ch_if.ch    <= c;
    do @(posedge clk); while (!ch_if.ready);
    sb.note_char(c);
  endtask

  task automatic send_chars(input logic [15:0] q[$]);
    foreach (q[i]) send_char(q[i]);
  endtask

  task automatic send_text(input string s);
    logic [15:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back({8'h00, s[i]});
    q.push_back(END_CHAR);
    send_chars(q);
  endtask

  function automatic logic [255:0] pack_text(input string s);
    logic [255:0] pk;
    pk = '0;
    for (int i = 0; i < s.len() && i < gwm_pkg::HELD_CHARS; i++) begin
      pk[16*i +: 16] = {8'h00, s[i]};
    end
    return pk;
  endfunction

  // Mostly a small alphabet so that literals in the pattern get hit.
  function automatic logic [15:0] alpha_char();
    if ($urandom_range(0, 99) < 85) return 16'(16'h0061 + $urandom_range(0, 2));
    return 16'($urandom_range(1, 65535));
  endfunction

  task automatic random_pattern();
    logic [255:0] pk;
    logic [63:0]  len_word;
    int unsigned  r;
    int unsigned  len;
    for (int i = 0; i < gwm_pkg::HELD_CHARS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        pk[16*i +: 16] = STAR16;
      end else if (r < 35) begin
        pk[16*i +: 16] = QUEST16;
      end else if (r < 92) begin
        pk[16*i +: 16] = 16'(16'h0061 + $urandom_range(0, 2));
      end else if (r < 99) begin
        pk[16*i +: 16] = 16'($urandom_range(1, 65535));
      end else begin
        pk[16*i +: 16] = '0;
      end
    end
    if ($urandom_range(0, 99) < 8) pk = {8{$urandom()}};
    r = $urandom_range(0, 99);
    if (r < 8) begin
      len = $urandom_range(gwm_pkg::MAX_PATTERN_DEF + 1, 31);
    end else if (r < 14) begin
      len = 0;
    end else if (r < 24) begin
      len = gwm_pkg::MAX_PATTERN_DEF;
    end else begin
      len = $urandom_range(1, gwm_pkg::MAX_PATTERN_DEF);
    end
    len_word = 64'(len);
    if ($urandom_range(0, 99) < 20) begin
      len_word = {$urandom(), $urandom()};
      len_word[gwm_pkg::LEN_BITS-1:0] = gwm_pkg::LEN_BITS'(len);
    end
    program_pattern(pk, len_word);
  endtask

  initial begin
    int unsigned base;
    int unsigned n;
    int unsigned cut;
    int unsigned pos;
    logic [15:0] p;
    logic [15:0] head[$];
    logic [15:0] tail[$];

    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    ch_if.valid <= 1'b0;
    ch_if.ch    <= '0;
    quiet       <= 1'b0;
    phases      = 0;
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Reset pattern is empty: only the empty string matches.
    send_text("");
    send_text("x");

    settle();
    program_pattern(pack_text("a*b?"), 4);
    text = '{16'h0061, 16'hFFFF, 16'h0001, 16'h0062, 16'h0063, END_CHAR};
    send_chars(text);

    // A zero character inside the length cuts the pattern short.
    settle();
    program_pattern(pack_text("ab") | (pack_text("cd") << 48), 5);
    send_text("ab");

    // Length above the maximum, and a chain of stars that matches even the empty string.
    settle();
    program_pattern(pack_text("****************"), 31);
    send_text("");

    settle();
    program_pattern('1, gwm_pkg::MAX_PATTERN_DEF);
    text = '{16'hFFFF, END_CHAR};
    send_chars(text);

    // Pattern swapped halfway through a string.
    settle();
    program_pattern(pack_text("a?"), 2);
    text = '{16'h0061};
    send_chars(text);
    settle();
    program_pattern(pack_text("ab*"), 3);
    send_text("b");

    // Once every position has died, the rest of the string cannot revive it.
    settle();
    program_pattern(pack_text("ab"), 2);
    send_text("xab");

    settle();
    program_pattern(pack_text("?"), 1);
    send_text("");

    base = sb.n_chars;
    while (sb.n_chars < base + RANDOM_ITEMS) begin
      settle();
      random_pattern();
      phases++;
      repeat ($urandom_range(1, 8)) begin
        quiet <= (sb.n_chars - base >= QUIET_FROM) && (sb.n_chars - base < QUIET_TO);
        text.delete();
        n = sb.eff_len();
        if ($urandom_range(0, 99) < 70) begin
          // Walk the pattern so that the string tends to get deep into it.
          for (int unsigned i = 0; i < n; i++) begin
            p = sb.pat_char(i);
            if (p == STAR16) begin
              repeat ($urandom_range(0, 3)) text.push_back(alpha_char());
            end else if (p == QUEST16) begin
              text.push_back(alpha_char());
            end else begin
              text.push_back(p);
            end
          end
          if (text.size() > 0 && $urandom_range(0, 99) < 30) begin
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 2))
              0: begin
                text.delete(pos);
              end
              1: begin
                text.insert(pos, alpha_char());
              end
              default: begin
                text[pos] = alpha_char();
              end
            endcase
          end
        end else begin
          repeat ($urandom_range(0, 10)) text.push_back(alpha_char());
        end
        text.push_back(END_CHAR);
        if (text.size() > 1 && $urandom_range(0, 99) < 5) begin
          cut  = $urandom_range(1, text.size() - 1);
          head = text[0:cut-1];
          tail = text[cut:$];
          send_chars(head);
          settle();
          random_pattern();
          phases++;
          send_chars(tail);
        end else begin
          send_chars(text);
        end
      end
    end
    quiet <= 1'b0;

    settle();
    $display("Covered %0d strings, %0d characters in all, under %0d programmed patterns.",
             sb.n_strings, sb.n_chars, phases + 8);
    $display("%0d strings matched and %0d did not.", sb.n_hits, sb.n_strings - sb.n_hits);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/gwm_pkg.sv
hw/rtl/gwm_ch_if.sv
hw/rtl/gwm_res_if.sv
hw/rtl/gwm_cfg_regs.sv
hw/rtl/gwm_cell.sv
hw/rtl/wildcard_glob_matcher_top.sv
bench/tb_wildcard_glob_matcher_top.sv
